>>> rtl/core/assert_macros.svh
// Assertion helpers for the quadratic root solver.
// Both macros expect clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define QRS_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication after a fixed number of cycles
`define QRS_ASSERT_DLY(label, ante, dly, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##dly (cons)) \
		else $error(msg);

`endif

>>> rtl/core/qrs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package qrs_pkg;

	localparam int FRAC_BITS = 16;
	localparam int DW        = 32;
	// discriminant magnitude is below 2^65
	localparam int RAD_W     = 66;
	localparam int ROOT_W    = RAD_W / 2;
	localparam int REM_W     = ROOT_W + 2;
	// numerator magnitude below 2^34, divisor |2a| up to 2^32
	localparam int NMAG_W    = 34;
	localparam int NUM_W     = NMAG_W + 1;
	localparam int DEN_W     = DW + 1;
	localparam int DIVD_W    = NMAG_W + FRAC_BITS;
	localparam int DIV_LAT   = DIVD_W + 2;
	localparam int TOTAL_LAT = ROOT_W + DIVD_W + 6;

	localparam logic [DW-1:0] POS_MAX = {1'b0, {(DW-1){1'b1}}};
	localparam logic [DW-1:0] NEG_MIN = {1'b1, {(DW-1){1'b0}}};

	typedef struct packed {
		logic signed [DW-1:0] coef_square;
		logic signed [DW-1:0] coef_linear;
		logic signed [DW-1:0] coef_constant;
	} qrs_in_t;

	typedef struct packed {
		logic signed [DW-1:0] first_value;
		logic signed [DW-1:0] second_value;
		logic                 roots_complex;
		logic                 leading_zero;
		logic                 saturated;
	} qrs_out_t;

	// flags and coefficients that ride along the square root pipe
	typedef struct packed {
		logic                 a_zero;
		logic                 dneg;
		logic signed [DW-1:0] coef_linear;
		logic signed [DW-1:0] coef_square;
	} qrs_side_t;

endpackage
`default_nettype wire

>>> rtl/core/qrs_disc.sv
`timescale 1ns / 1ps
`default_nettype none
module qrs_disc
	import qrs_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              vld,
	input  wire qrs_in_t           opnd,
	output logic                   out_vld,
	output logic [RAD_W-1:0]       rad,
	output qrs_side_t              side
);

	logic [DW-1:0]     mag_a, mag_b, mag_c;
	logic              vld_s1, vld_s2;
	logic [2*DW-1:0]   prod_s1, bsq_s1;
	logic              opp_s1, azero_s1;
	logic signed [DW-1:0] a_s1, b_s1;
	logic [RAD_W-1:0]  q4, bb, d_sum, d_pos, d_neg, rad_s2;
	logic              le, opp_nz;
	qrs_side_t         side_s2;

	// magnitudes of the coefficients
	always_comb begin
		mag_a = opnd.coef_square[DW-1]   ? DW'(0 - opnd.coef_square)   : opnd.coef_square;
		mag_b = opnd.coef_linear[DW-1]   ? DW'(0 - opnd.coef_linear)   : opnd.coef_linear;
		mag_c = opnd.coef_constant[DW-1] ? DW'(0 - opnd.coef_constant) : opnd.coef_constant;
	end

	// stage 1: products
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= vld;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1  <= mag_a * mag_c;
		bsq_s1   <= mag_b * mag_b;
		opp_s1   <= opnd.coef_square[DW-1] ^ opnd.coef_constant[DW-1];
		azero_s1 <= (opnd.coef_square == '0);
		a_s1     <= opnd.coef_square;
		b_s1     <= opnd.coef_linear;
	end

	// discriminant magnitude and sign
	always_comb begin
		q4     = {prod_s1, 2'b00};
		bb     = {2'b00, bsq_s1};
		d_sum  = bb + q4;
		d_pos  = bb - q4;
		d_neg  = q4 - bb;
		le     = (q4 <= bb);
		opp_nz = opp_s1 && (prod_s1 != '0);
	end

	// stage 2
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		rad_s2              <= opp_nz ? d_sum : (le ? d_pos : d_neg);
		side_s2.dneg        <= !opp_nz && !le;
		side_s2.a_zero      <= azero_s1;
		side_s2.coef_linear <= b_s1;
		side_s2.coef_square <= a_s1;
	end

	assign out_vld = vld_s2;
	assign rad     = rad_s2;
	assign side    = side_s2;

endmodule
`default_nettype wire

>>> rtl/core/qrs_sqrt.sv
`timescale 1ns / 1ps
`default_nettype none
module qrs_sqrt
	import qrs_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              vld,
	input  wire logic [RAD_W-1:0]  rad,
	input  wire qrs_side_t         side_in,
	output logic                   out_vld,
	output logic [ROOT_W-1:0]      root,
	output qrs_side_t              side_out
);

	// one root bit per stage
	logic              vld_sn  [0:ROOT_W-1];
	logic [RAD_W-1:0]  rad_sn  [0:ROOT_W-1];
	logic [REM_W-1:0]  rem_sn  [0:ROOT_W-1];
	logic [ROOT_W-1:0] root_sn [0:ROOT_W-1];
	qrs_side_t         side_sn [0:ROOT_W-1];

	for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
		logic              vld_i;
		logic [RAD_W-1:0]  rad_i;
		logic [REM_W-1:0]  rem_i;
		logic [ROOT_W-1:0] root_i;
		qrs_side_t         side_i;
		logic [REM_W+1:0]  trial, test;
		logic              ge;

		if (k == 0) begin : g_first
			assign vld_i  = vld;
			assign rad_i  = rad;
			assign rem_i  = '0;
			assign root_i = '0;
			assign side_i = side_in;
		end else begin : g_rest
			assign vld_i  = vld_sn[k-1];
			assign rad_i  = rad_sn[k-1];
			assign rem_i  = rem_sn[k-1];
			assign root_i = root_sn[k-1];
			assign side_i = side_sn[k-1];
		end

		// bring down two radicand bits, test against 4*root+1
		always_comb begin
			trial = {rem_i, rad_i[RAD_W-1 -: 2]};
			test  = {2'b00, root_i, 2'b01};
			ge    = (trial >= test);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_sn[k] <= 1'b0;
			end else begin
				vld_sn[k] <= vld_i;
			end
		end

		always_ff @(posedge clk) begin
			rem_sn[k]  <= ge ? REM_W'(trial - test) : REM_W'(trial);
			root_sn[k] <= {root_i[ROOT_W-2:0], ge};
			rad_sn[k]  <= {rad_i[RAD_W-3:0], 2'b00};
			side_sn[k] <= side_i;
		end
	end

	assign out_vld  = vld_sn[ROOT_W-1];
	assign root     = root_sn[ROOT_W-1];
	assign side_out = side_sn[ROOT_W-1];

endmodule
`default_nettype wire

>>> rtl/core/qrs_div.sv
`timescale 1ns / 1ps
`default_nettype none
module qrs_div
	import qrs_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    vld,
	input  wire logic signed [NUM_W-1:0] num,
	input  wire logic signed [DEN_W-1:0] den,
	output logic                         out_vld,
	output logic signed [DW-1:0]         quot,
	output logic                         sat
);

	// stage 1: magnitudes and result sign
	logic              vld_s1, neg_s1;
	logic [DIVD_W-1:0] dvd_s1;
	logic [DEN_W-1:0]  dmag_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= vld;
		end
	end

	always_ff @(posedge clk) begin
		dvd_s1  <= {(num[NUM_W-1] ? NMAG_W'(0 - num) : NMAG_W'(num)), {FRAC_BITS{1'b0}}};
		dmag_s1 <= den[DEN_W-1] ? DEN_W'(0 - den) : DEN_W'(den);
		neg_s1  <= num[NUM_W-1] ^ den[DEN_W-1];
	end

	// restoring division, one quotient bit per stage
	logic              vld_sn  [0:DIVD_W-1];
	logic              neg_sn  [0:DIVD_W-1];
	logic [DIVD_W-1:0] dvd_sn  [0:DIVD_W-1];
	logic [DIVD_W-1:0] quo_sn  [0:DIVD_W-1];
	logic [DEN_W-1:0]  rem_sn  [0:DIVD_W-1];
	logic [DEN_W-1:0]  dmag_sn [0:DIVD_W-1];

	for (genvar k = 0; k < DIVD_W; k++) begin : g_stage
		logic              vld_i, neg_i;
		logic [DIVD_W-1:0] dvd_i, quo_i;
		logic [DEN_W-1:0]  rem_i, dmag_i;
		logic [DEN_W:0]    trial;
		logic              ge;

		if (k == 0) begin : g_first
			assign vld_i  = vld_s1;
			assign neg_i  = neg_s1;
			assign dvd_i  = dvd_s1;
			assign quo_i  = '0;
			assign rem_i  = '0;
			assign dmag_i = dmag_s1;
		end else begin : g_rest
			assign vld_i  = vld_sn[k-1];
			assign neg_i  = neg_sn[k-1];
			assign dvd_i  = dvd_sn[k-1];
			assign quo_i  = quo_sn[k-1];
			assign rem_i  = rem_sn[k-1];
			assign dmag_i = dmag_sn[k-1];
		end

		always_comb begin
			trial = {rem_i, dvd_i[DIVD_W-1]};
			ge    = (trial >= {1'b0, dmag_i});
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_sn[k] <= 1'b0;
			end else begin
				vld_sn[k] <= vld_i;
			end
		end

		always_ff @(posedge clk) begin
			rem_sn[k]  <= ge ? DEN_W'(trial - {1'b0, dmag_i}) : DEN_W'(trial);
			quo_sn[k]  <= {quo_i[DIVD_W-2:0], ge};
			dvd_sn[k]  <= {dvd_i[DIVD_W-2:0], 1'b0};
			dmag_sn[k] <= dmag_i;
			neg_sn[k]  <= neg_i;
		end
	end

	// final stage: sign and clamp
	logic [DIVD_W-1:0] q;
	logic              neg, ovf_pos, ovf_neg;
	logic              vld_s3, sat_s3;
	logic [DW-1:0]     quot_s3;

	always_comb begin
		q       = quo_sn[DIVD_W-1];
		neg     = neg_sn[DIVD_W-1];
		ovf_pos = !neg && (|q[DIVD_W-1:DW-1]);
		ovf_neg = neg && ((|q[DIVD_W-1:DW]) || (q[DW-1] && (|q[DW-2:0])));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= vld_sn[DIVD_W-1];
		end
	end

	always_ff @(posedge clk) begin
		sat_s3 <= ovf_pos || ovf_neg;
		if (ovf_pos) begin
			quot_s3 <= POS_MAX;
		end else if (ovf_neg) begin
			quot_s3 <= NEG_MIN;
		end else begin
			quot_s3 <= neg ? DW'(0 - q[DW-1:0]) : q[DW-1:0];
		end
	end

	assign out_vld = vld_s3;
	assign quot    = quot_s3;
	assign sat     = sat_s3;

endmodule
`default_nettype wire

>>> rtl/core/quadratic_root_solver_top.sv
`timescale 1ns / 1ps
// Channel | Handshake    | Payload
// input   | start / busy | operands (qrs_in_t: a, b, c)
// output  | done         | result   (qrs_out_t: values and flags)
//
// Latency is set by the bit-per-stage square root (33 stages) and the
// bit-per-stage dividers (50 stages).
// A new coefficient set is taken every cycle; busy stays low.
// done is high for one cycle per beat; the result is not held.
// arst_n clears the valid bits only; data registers are not reset.
`default_nettype none
module quadratic_root_solver_top
	import qrs_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    start,
	output logic         busy,
	input  wire qrs_in_t operands,
	output logic         done,
	output qrs_out_t     result
);

	`include "assert_macros.svh"

	logic              acc;
	logic              d_vld, r_vld, q1_vld, q2_vld;
	logic [RAD_W-1:0]  rad;
	logic [ROOT_W-1:0] root;
	qrs_side_t         d_side, r_side;
	logic signed [DW-1:0] q1, q2;
	logic              sat1, sat2;

	assign busy = 1'b0;
	assign acc  = start && !busy;

	qrs_disc u_disc (
		.clk     (clk),
		.arst_n  (arst_n),
		.vld     (acc),
		.opnd    (operands),
		.out_vld (d_vld),
		.rad     (rad),
		.side    (d_side)
	);

	qrs_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.vld      (d_vld),
		.rad      (rad),
		.side_in  (d_side),
		.out_vld  (r_vld),
		.root     (root),
		.side_out (r_side)
	);

	// numerators and divisor
	logic signed [NUM_W-1:0] nb, ns;
	logic                    vld_s1, azero_s1, dneg_s1;
	logic signed [NUM_W-1:0] n1_s1, n2_s1;
	logic signed [DEN_W-1:0] den_s1;

	always_comb begin
		nb = NUM_W'(0 - {{(NUM_W-DW){r_side.coef_linear[DW-1]}}, r_side.coef_linear});
		ns = {{(NUM_W-ROOT_W){1'b0}}, root};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= r_vld;
		end
	end

	always_ff @(posedge clk) begin
		n1_s1    <= r_side.dneg ? nb : NUM_W'(nb + ns);
		n2_s1    <= r_side.dneg ? ns : NUM_W'(nb - ns);
		den_s1   <= {r_side.coef_square, 1'b0};
		azero_s1 <= r_side.a_zero;
		dneg_s1  <= r_side.dneg;
	end

	qrs_div u_div1 (
		.clk     (clk),
		.arst_n  (arst_n),
		.vld     (vld_s1),
		.num     (n1_s1),
		.den     (den_s1),
		.out_vld (q1_vld),
		.quot    (q1),
		.sat     (sat1)
	);

	qrs_div u_div2 (
		.clk     (clk),
		.arst_n  (arst_n),
		.vld     (vld_s1),
		.num     (n2_s1),
		.den     (den_s1),
		.out_vld (q2_vld),
		.quot    (q2),
		.sat     (sat2)
	);

	// flags travel alongside the dividers
	logic azero_sd [0:DIV_LAT-1];
	logic dneg_sd  [0:DIV_LAT-1];

	always_ff @(posedge clk) begin
		azero_sd[0] <= azero_s1;
		dneg_sd[0]  <= dneg_s1;
		for (int i = 1; i < DIV_LAT; i++) begin
			azero_sd[i] <= azero_sd[i-1];
			dneg_sd[i]  <= dneg_sd[i-1];
		end
	end

	// output register
	logic     done_s2;
	qrs_out_t result_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s2 <= 1'b0;
		end else begin
			done_s2 <= q1_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (azero_sd[DIV_LAT-1]) begin
			result_s2 <= '{first_value: '0, second_value: '0, roots_complex: 1'b0,
				leading_zero: 1'b1, saturated: 1'b0};
		end else begin
			result_s2 <= '{first_value: q1, second_value: q2,
				roots_complex: dneg_sd[DIV_LAT-1], leading_zero: 1'b0,
				saturated: sat1 || sat2};
		end
	end

	assign done   = done_s2;
	assign result = result_s2;

	// checks
	`QRS_ASSERT_DLY(a_latency, acc, TOTAL_LAT, done, "result beat missing after accept")
	`QRS_ASSERT_IMP(a_lanes, q1_vld || q2_vld, q1_vld && q2_vld, "dividers out of step")
	`QRS_ASSERT_IMP(a_zero_lead, done && result.leading_zero,
		result.first_value == '0 && result.second_value == '0 &&
		!result.roots_complex && !result.saturated, "leading-zero result not cleared")

endmodule
`default_nettype wire

>>> tb/sv/tb_quadratic_root_solver_top.sv
`timescale 1ns / 1ps
module tb_quadratic_root_solver_top;
	import qrs_pkg::*;

	localparam int SETTLE_CYCLES = TOTAL_LAT + 20;

	logic     clk;
	logic     arst_n;
	logic     start;
	logic     busy;
	qrs_in_t  operands;
	logic     done;
	qrs_out_t result;

	qrs_out_t expected_roots[$];
	int       mismatch_count;
	int       orphan_count;

	quadratic_root_solver_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.operands(operands),
		.done(done),
		.result(result)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// floor(sqrt(v)) for v below 2^66, bit by bit
	function automatic logic [ROOT_W-1:0] floor_sqrt(input logic [RAD_W-1:0] v);
		logic [ROOT_W-1:0] r;
		logic [ROOT_W-1:0] t;
		logic [2*ROOT_W-1:0] sq;
		r = '0;
		for (int i = ROOT_W - 1; i >= 0; i--) begin
			t = r | (1 << i);
			sq = t * t;
			if (sq <= v)
				r = t;
		end
		return r;
	endfunction

	// (num << FRAC_BITS) / den, toward zero, clamped to 32 bits
	function automatic logic [DW-1:0] scaled_quotient(input logic signed [79:0] num,
			input logic signed [79:0] den, inout logic sat);
		logic [79:0] un;
		logic [79:0] ud;
		logic [79:0] q;
		logic        neg;
		un = (num < 0) ? -num : num;
		ud = (den < 0) ? -den : den;
		un = un << FRAC_BITS;
		q = un / ud;
		neg = (num < 0) != (den < 0);
		if (!neg && q > 80'h7FFF_FFFF) begin
			sat = 1'b1;
			return POS_MAX;
		end
		if (neg && q > 80'h8000_0000) begin
			sat = 1'b1;
			return NEG_MIN;
		end
		return neg ? DW'(-q) : DW'(q);
	endfunction

	function automatic qrs_out_t solve_roots(input qrs_in_t x);
		qrs_out_t r;
		logic signed [79:0] a;
		logic signed [79:0] b;
		logic signed [79:0] c;
		logic signed [79:0] disc;
		logic [RAD_W-1:0]   mag;
		logic signed [79:0] s;
		logic               sat;
		a = x.coef_square;
		b = x.coef_linear;
		c = x.coef_constant;
		r = '0;
		sat = 1'b0;
		if (a == 0) begin
			r.leading_zero = 1'b1;
			return r;
		end
		disc = b * b - 4 * a * c;
		mag = RAD_W'((disc < 0) ? -disc : disc);
		s = floor_sqrt(mag);
		if (disc >= 0) begin
			r.first_value = scaled_quotient(-b + s, 2 * a, sat);
			r.second_value = scaled_quotient(-b - s, 2 * a, sat);
		end else begin
			r.first_value = scaled_quotient(-b, 2 * a, sat);
			r.second_value = scaled_quotient(s, 2 * a, sat);
			r.roots_complex = 1'b1;
		end
		r.saturated = sat;
		return r;
	endfunction

	// result checker: each done beat against the oldest expectation
	always @(posedge clk) begin
		qrs_out_t want;
		if (arst_n && done) begin
			if (expected_roots.size() == 0) begin
				orphan_count++;
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected result beat %h", result);
			end else begin
				want = expected_roots.pop_front();
				if (result.first_value !== want.first_value
						|| result.second_value !== want.second_value
						|| result.roots_complex !== want.roots_complex
						|| result.leading_zero !== want.leading_zero
						|| result.saturated !== want.saturated) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("mismatch: exp %h %h c%b z%b s%b got %h %h c%b z%b s%b",
							want.first_value, want.second_value, want.roots_complex,
							want.leading_zero, want.saturated, result.first_value,
							result.second_value, result.roots_complex,
							result.leading_zero, result.saturated);
				end
			end
		end
	end

	// one beat in, with an optional random gap before it
	task automatic send_coefs(input qrs_in_t x, input bit allow_gap);
		int gap;
		gap = 0;
		if (allow_gap) begin
			if ($urandom_range(0, 19) == 0)
				gap = $urandom_range(10, 60);
			else if ($urandom_range(0, 2) == 0)
				gap = $urandom_range(1, 3);
		end
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		operands <= x;
		@(posedge clk);
		while (busy) @(posedge clk);
		expected_roots.push_back(solve_roots(x));
	endtask

	function automatic logic [DW-1:0] pick_coef();
		case ($urandom_range(0, 5))
			0: return $urandom_range(0, 1) ? POS_MAX : NEG_MIN;
			1: return DW'($signed($urandom_range(0, 8)) - 4) << FRAC_BITS;
			2: return DW'($signed($urandom_range(0, 2000)) - 1000);
			3: return $urandom_range(0, 1) ? 32'd0 : 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	task automatic run_directed();
		qrs_in_t x;
		logic [DW-1:0] ex[6];
		ex = '{POS_MAX, NEG_MIN, 32'd0, 32'hFFFF_FFFF, 32'h0001_0000, 32'hFFFF_0000};
		// leading zero, real roots, double root, complex and negative-a complex
		x = '{32'd0, 32'h0003_0000, 32'h0001_0000};            send_coefs(x, 0);
		x = '{32'h0001_0000, 32'hFFFD_0000, 32'h0002_0000};    send_coefs(x, 0);
		x = '{32'h0001_0000, 32'h0002_0000, 32'h0001_0000};    send_coefs(x, 0);
		x = '{32'h0001_0000, 32'd0, 32'h0001_0000};            send_coefs(x, 0);
		x = '{32'hFFFF_0000, 32'd0, 32'hFFFF_0000};            send_coefs(x, 0);
		// tiny a forces saturation
		x = '{32'd1, POS_MAX, 32'd0};                          send_coefs(x, 0);
		for (int i = 0; i < 6; i++) begin
			x = '{ex[i], ex[(i + 1) % 6], ex[(i + 3) % 6]};
			send_coefs(x, 0);
			x = '{ex[i], ex[i], ex[i]};
			send_coefs(x, 1);
		end
	endtask

	task automatic run_random();
		qrs_in_t x;
		for (int i = 0; i < 1000; i++) begin
			x.coef_square = pick_coef();
			x.coef_linear = pick_coef();
			x.coef_constant = pick_coef();
			send_coefs(x, (i % 200) < 150);
		end
	endtask

	task automatic drain_results();
		start <= 1'b0;
		while (expected_roots.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		mismatch_count = 0;
		orphan_count = 0;
		arst_n = 1'b0;
		start = 1'b0;
		operands = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		run_random();
		drain_results();
		if (mismatch_count == 0 && expected_roots.size() == 0)
			$display("tb_quadratic_root_solver_top passed");
		else
			$display("tb_quadratic_root_solver_top failed");
		$finish;
	end

	// watchdog
	initial begin
		#20ms;
		$display("tb_quadratic_root_solver_top failed");
		$finish;
	end

endmodule
